@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

@@ hw/rtl/eabv_pkg.sv @@
`timescale 1ns / 1ps
package eabv_pkg;
	localparam int unsigned FULL_TURN = 23040;
	localparam int unsigned RECIP_HI = 186413;
	localparam int unsigned RECIP_LO = 1491309;
	localparam int unsigned RECIP_SH = 26;
	localparam logic signed [33:0] X_INIT = 34'sh026DD3B6A;

	typedef struct packed {
		logic signed [15:0] yaw_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] right_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
		logic signed [15:0] forward_x;
		logic signed [15:0] forward_y;
		logic signed [15:0] forward_z;
	} out_word_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051D;
			5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2E;
			5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2F9; 5'd15: v = 32'h0000517C;
			5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A2F; 5'd19: v = 32'h00000517;
			5'd20: v = 32'h0000028B; 5'd21: v = 32'h00000145;
			5'd22: v = 32'h000000A2; 5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000028; 5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000002; 5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	function automatic logic signed [33:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b + 64'sd536870912;
		return 34'(p >>> 30);
	endfunction
endpackage

@@ hw/rtl/eabv_reduce.sv @@
`timescale 1ns / 1ps
module eabv_reduce import eabv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vin,
	input  in_word_t           word,
	output logic               vout,
	output logic signed [33:0] z [3],
	output logic [1:0]         quad [3]
);
	logic [14:0] r_s1 [3];
	logic [32:0] hi_s2 [3];
	logic [14:0] lo_s2 [3];
	logic        v_s1, v_s2, v_s3;
	logic signed [15:0] ang [3];

	assign ang[0] = word.yaw_angle;
	assign ang[1] = word.pitch_angle;
	assign ang[2] = word.roll_angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic signed [16:0] a_ext, r_c;
		logic [19:0] num;
		logic [40:0] prod;
		logic [31:0] phase, res;
		logic [1:0]  qd;

		always_comb begin
			a_ext = 17'(ang[l]);
			priority if (a_ext < -17'sd23040) r_c = a_ext + 17'sd46080;
			else if (a_ext < 17'sd0) r_c = a_ext + 17'sd23040;
			else if (a_ext >= 17'sd23040) r_c = a_ext - 17'sd23040;
			else r_c = a_ext;
			num = 20'(r_s1[l]) * 20'd23 + 20'd22;
			prod = 41'(num) * 41'(RECIP_LO);
			phase = 32'(hi_s2[l] + 33'(lo_s2[l]));
			qd = 2'((phase + 32'h2000_0000) >> 30);
			res = phase - {qd, 30'b0};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s1[l]  <= r_c[14:0];
				hi_s2[l] <= 33'(r_s1[l]) * 33'(RECIP_HI);
				lo_s2[l] <= prod[RECIP_SH +: 15];
				z[l]     <= 34'(signed'(res));
				quad[l]  <= qd;
			end
		end
	end

	assign vout = v_s3;
endmodule

@@ hw/rtl/eabv_cordic.sv @@
`timescale 1ns / 1ps
module eabv_cordic import eabv_pkg::*; #(
	parameter int STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vin,
	input  logic signed [33:0] z [3],
	input  logic [1:0]         quad [3],
	output logic               vout,
	output logic signed [31:0] sn [3],
	output logic signed [31:0] cs [3]
);
	logic signed [33:0] x_s [STAGES+1][3];
	logic signed [33:0] y_s [STAGES+1][3];
	logic signed [33:0] z_s [STAGES+1][3];
	logic [1:0]         q_s [STAGES+1][3];
	logic               v_s [STAGES+1];
	logic               v_map_q;

	assign v_s[0] = vin;

	for (genvar l = 0; l < 3; l++) begin : g_in
		assign x_s[0][l] = X_INIT;
		assign y_s[0][l] = '0;
		assign z_s[0][l] = z[l];
		assign q_s[0][l] = quad[l];
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic [33:0] ATAN = 34'(atan_entry(5'(i)));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		for (genvar l = 0; l < 3; l++) begin : g_lane
			always_ff @(posedge clk) begin
				if (en) begin
					q_s[i+1][l] <= q_s[i][l];
					if (z_s[i][l] >= 0) begin
						x_s[i+1][l] <= x_s[i][l] - (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] + (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] - signed'(ATAN);
					end else begin
						x_s[i+1][l] <= x_s[i][l] + (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] - (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] + signed'(ATAN);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_map_q <= 1'b0;
		end else if (en) begin
			v_map_q <= v_s[STAGES];
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_map
		logic signed [33:0] xf, yf;
		assign xf = x_s[STAGES][l];
		assign yf = y_s[STAGES][l];
		always_ff @(posedge clk) begin
			if (en) begin
				unique case (q_s[STAGES][l])
					2'd0: begin cs[l] <= xf[31:0]; sn[l] <= yf[31:0]; end
					2'd1: begin cs[l] <= 32'(-yf); sn[l] <= xf[31:0]; end
					2'd2: begin cs[l] <= 32'(-xf); sn[l] <= 32'(-yf); end
					default: begin cs[l] <= yf[31:0]; sn[l] <= 32'(-xf); end
				endcase
			end
		end
	end

	assign vout = v_map_q;
endmodule

@@ hw/rtl/eabv_basis.sv @@
`timescale 1ns / 1ps
module eabv_basis import eabv_pkg::*; #(
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vin,
	input  logic signed [31:0] sn [3],
	input  logic signed [31:0] cs [3],
	output logic               vout,
	output out_word_t          word
);
	localparam int SH = 30 - OUT_FRAC_BITS;
	localparam int RND_SH = (SH > 0) ? SH - 1 : 0;
	localparam logic signed [36:0] RND = (SH > 0) ? (37'sd1 <<< RND_SH) : 37'sd0;
	localparam logic signed [36:0] LIM = 37'sd1 <<< OUT_FRAC_BITS;

	logic signed [33:0] cpcy_s1, cpsy_s1, t1_s1, crsy_s1, crcy_s1;
	logic signed [33:0] srcp_s1, t2_s1, srsy_s1, srcy_s1, crcp_s1;
	logic signed [31:0] sp_s1, cy_s1, sy_s1;
	logic signed [33:0] cpcy_s2, cpsy_s2, crsy_s2, crcy_s2, srcp_s2;
	logic signed [33:0] srsy_s2, srcy_s2, crcp_s2, a_s2, b_s2, c_s2, d_s2;
	logic signed [31:0] sp_s2;
	logic v_s1, v_s2, v_s3;

	function automatic logic signed [15:0] to_out(input logic signed [36:0] v);
		logic signed [36:0] r;
		r = (v + RND) >>> SH;
		if (r > LIM) r = LIM;
		if (r < -LIM) r = -LIM;
		return r[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cpcy_s1 <= qmul(cs[1], cs[0]);
			cpsy_s1 <= qmul(cs[1], sn[0]);
			t1_s1   <= qmul(sn[2], sn[1]);
			crsy_s1 <= qmul(cs[2], sn[0]);
			crcy_s1 <= qmul(cs[2], cs[0]);
			srcp_s1 <= qmul(sn[2], cs[1]);
			t2_s1   <= qmul(cs[2], sn[1]);
			srsy_s1 <= qmul(sn[2], sn[0]);
			srcy_s1 <= qmul(sn[2], cs[0]);
			crcp_s1 <= qmul(cs[2], cs[1]);
			sp_s1 <= sn[1];
			cy_s1 <= cs[0];
			sy_s1 <= sn[0];

			cpcy_s2 <= cpcy_s1;
			cpsy_s2 <= cpsy_s1;
			crsy_s2 <= crsy_s1;
			crcy_s2 <= crcy_s1;
			srcp_s2 <= srcp_s1;
			srsy_s2 <= srsy_s1;
			srcy_s2 <= srcy_s1;
			crcp_s2 <= crcp_s1;
			sp_s2   <= sp_s1;
			a_s2 <= qmul(t1_s1[31:0], cy_s1);
			b_s2 <= qmul(t1_s1[31:0], sy_s1);
			c_s2 <= qmul(t2_s1[31:0], cy_s1);
			d_s2 <= qmul(t2_s1[31:0], sy_s1);

			word.right_x   <= to_out(37'(cpcy_s2));
			word.right_y   <= to_out(37'(cpsy_s2));
			word.right_z   <= to_out(-37'(sp_s2));
			word.up_x      <= to_out(37'(crsy_s2) - 37'(a_s2));
			word.up_y      <= to_out(-37'(b_s2) - 37'(crcy_s2));
			word.up_z      <= to_out(-37'(srcp_s2));
			word.forward_x <= to_out(37'(c_s2) + 37'(srsy_s2));
			word.forward_y <= to_out(37'(d_s2) - 37'(srcy_s2));
			word.forward_z <= to_out(37'(crcp_s2));
		end
	end

	assign vout = v_s3;
endmodule

@@ hw/rtl/euler_angles_to_basis_vectors_core.sv @@
// Path: an accepted angle word passes the reduction, CORDIC, quadrant-map and basis registers to its result word.
// Throughput: one word per cycle while the output is not stalled; the whole pipeline advances together,
// one CORDIC iteration per register stage, three angles in parallel lanes.
// Reset: arst_n clears all valid bits asynchronously; data registers hold.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module euler_angles_to_basis_vectors_core import eabv_pkg::*; #(
	parameter int OUT_FRAC_BITS = 14,
	parameter int CORDIC_STAGES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_word_t  req_word,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_word_t rsp_word
);
	logic adv, v_red, v_cor;
	logic signed [33:0] z [3];
	logic [1:0] quad [3];
	logic signed [31:0] sn [3], cs [3];

	assign adv = !rsp_valid || rsp_ready;
	assign req_ready = adv;

	eabv_reduce u_reduce (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(req_valid),
		.word(req_word), .vout(v_red), .z(z), .quad(quad)
	);

	eabv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_red),
		.z(z), .quad(quad), .vout(v_cor), .sn(sn), .cs(cs)
	);

	eabv_basis #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_basis (
		.clk(clk), .arst_n(arst_n), .en(adv), .vin(v_cor),
		.sn(sn), .cs(cs), .vout(rsp_valid), .word(rsp_word)
	);

	`ASSERT_NEXT(a_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
	`ASSERT_CLK(a_rx, clk, arst_n, !rsp_valid || (rsp_word.right_x <= 16'sd16384 && rsp_word.right_x >= -16'sd16384), "right_x range")
	`ASSERT_CLK(a_fz, clk, arst_n, !rsp_valid || (rsp_word.forward_z <= 16'sd16384 && rsp_word.forward_z >= -16'sd16384), "forward_z range")
	`ASSERT_CLK(a_stall, clk, arst_n, !req_ready |-> rsp_valid, "stall without result")
endmodule

@@ tb/sv/euler_angles_to_basis_vectors_core_tb.sv @@
`timescale 1ns / 1ps
module euler_angles_to_basis_vectors_core_tb;
	import eabv_pkg::*;

	localparam int FRAC = 14;
	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 7;
	localparam longint CYCLE_LIMIT = 400000;

	function automatic longint shr_floor(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint mul_q30(input longint a, input longint b);
		return shr_floor(a * b + (longint'(1) << 29), 30);
	endfunction

	function automatic logic [31:0] arctan_step(input int i);
		logic [31:0] t [0:31];
		t = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
			32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
			32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
			32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
			32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
			32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000};
		return t[i];
	endfunction

	function automatic void angle_sin_cos(input logic signed [15:0] ang, output longint s,
			output longint c);
		longint r, z, x, y, nx, ny, xs, ys;
		logic [63:0] wide;
		logic [31:0] phase, res;
		logic [1:0] quad;
		r = longint'(ang) % longint'(FULL_TURN);
		if (r < 0) r += longint'(FULL_TURN);
		wide = ((64'(r)) << 32) + 64'd11520;
		phase = 32'(wide / 64'd23040);
		quad = 2'((phase + 32'h20000000) >> 30);
		res = phase - ({30'd0, quad} << 30);
		z = longint'(signed'(res));
		x = 64'h26DD3B6A;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				nx = x - ys; ny = y + xs; z -= longint'(arctan_step(i));
			end else begin
				nx = x + ys; ny = y - xs; z += longint'(arctan_step(i));
			end
			x = nx; y = ny;
		end
		case (quad)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic logic signed [15:0] to_q14(input longint v);
		int sh;
		longint lim;
		sh = 30 - FRAC;
		lim = longint'(1) << FRAC;
		v = shr_floor(v + (longint'(1) << (sh - 1)), sh);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return 16'(v);
	endfunction

	function automatic void basis_from_angles(input in_word_t a, output out_word_t o);
		longint sy, cy, sp, cp, sr, cr, t;
		angle_sin_cos(a.yaw_angle, sy, cy);
		angle_sin_cos(a.pitch_angle, sp, cp);
		angle_sin_cos(a.roll_angle, sr, cr);
		o.right_x = to_q14(mul_q30(cp, cy));
		o.right_y = to_q14(mul_q30(cp, sy));
		o.right_z = to_q14(-sp);
		t = mul_q30(sr, sp);
		o.up_x = to_q14(-mul_q30(t, cy) + mul_q30(cr, sy));
		o.up_y = to_q14(-mul_q30(t, sy) - mul_q30(cr, cy));
		o.up_z = to_q14(-mul_q30(sr, cp));
		t = mul_q30(cr, sp);
		o.forward_x = to_q14(mul_q30(t, cy) + mul_q30(sr, sy));
		o.forward_y = to_q14(mul_q30(t, sy) - mul_q30(sr, cy));
		o.forward_z = to_q14(mul_q30(cr, cp));
	endfunction

	class basis_scoreboard;
		out_word_t pending_vectors[$];
		int mismatches;

		function void note_angles(in_word_t a);
			out_word_t o;
			basis_from_angles(a, o);
			pending_vectors.push_back(o);
		endfunction

		function void check_vectors(out_word_t got);
			out_word_t exp_w;
			if (pending_vectors.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %h", got);
				return;
			end
			exp_w = pending_vectors.pop_front();
			if (got !== exp_w) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h actual %h", exp_w, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_ready;
	in_word_t req_word = '0;
	logic rsp_valid;
	logic rsp_ready = 0;
	out_word_t rsp_word;
	int send_idle_pct = 35;
	int recv_idle_pct = 59;
	longint cycles = 0;
	basis_scoreboard sb = new();

	euler_angles_to_basis_vectors_core #(.OUT_FRAC_BITS(FRAC), .CORDIC_STAGES(STAGES)) u_dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.req_word(req_word), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
		.rsp_word(rsp_word));

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) sb.check_vectors(rsp_word);
		rsp_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_angles(input in_word_t a);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		req_word <= a;
		do @(posedge clk); while (!req_ready);
		sb.note_angles(a);
	endtask

	function automatic logic signed [15:0] pick_angle();
		case ($urandom_range(5))
			0: return 16'($urandom_range(8) * 2880 + $urandom_range(2) - 1);
			1: return -16'($urandom_range(8) * 2880);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [15:0] edges [0:9];
		in_word_t a;
		edges = '{16'sh7FFF, -16'sh8000, 0, 1, -1, 5760, 11520, 17280, -5760, 23040};
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < 10; i++) begin
			a.yaw_angle = edges[i];
			a.pitch_angle = edges[(i + 3) % 10];
			a.roll_angle = edges[(i + 7) % 10];
			send_angles(a);
		end
		for (int i = 0; i < 10; i++) begin
			a = '{edges[i], edges[i], edges[i]};
			send_angles(a);
		end
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin send_idle_pct = 59; recv_idle_pct = 35; end
			if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
			for (int n = 0; n < 660; n++) begin
				a = '{pick_angle(), pick_angle(), pick_angle()};
				send_angles(a);
			end
		end
		req_valid <= 0;
		while (sb.pending_vectors.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_vectors.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/eabv_pkg.sv
hw/rtl/eabv_reduce.sv
hw/rtl/eabv_cordic.sv
hw/rtl/eabv_basis.sv
hw/rtl/euler_angles_to_basis_vectors_core.sv
tb/sv/euler_angles_to_basis_vectors_core_tb.sv
